[rtl/lhm_pkg.sv]
// ----------------------------------------------------------------------------
// lhm_pkg
// Types and constants shared by the block latency histogram monitor.
// ----------------------------------------------------------------------------
package lhm_pkg;

	localparam int WORD_W      = 64;
	localparam int CYC_W       = 32;
	localparam int BKT_CFG_W   = 28;
	localparam int DEPTH_W     = 16;
	localparam int WI_W        = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int DIV_STEPS_W = 7;
	localparam int PROD_W      = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIKE  = 2'd2;

	localparam logic [CYC_W-1:0]     BUDGET_RST = 32'd1280000;
	localparam logic [BKT_CFG_W-1:0] BUCKET_RST = 28'd80000;
	localparam logic [CYC_W-1:0]     SPIKE_RST  = 32'd1024000;

	// report word indexes
	localparam logic [WI_W-1:0] WI_COUNT   = 5'd0;
	localparam logic [WI_W-1:0] WI_MIN     = 5'd1;
	localparam logic [WI_W-1:0] WI_MEAN    = 5'd2;
	localparam logic [WI_W-1:0] WI_P99     = 5'd3;
	localparam logic [WI_W-1:0] WI_MAX     = 5'd4;
	localparam logic [WI_W-1:0] WI_PCT     = 5'd5;
	localparam logic [WI_W-1:0] WI_SPIKES  = 5'd6;
	localparam logic [WI_W-1:0] WI_OVER    = 5'd7;
	localparam logic [WI_W-1:0] WI_NUMBER  = 5'd8;
	localparam logic [WI_W-1:0] WI_DEPTH   = 5'd9;
	localparam logic [WI_W-1:0] WI_TICK    = 5'd10;
	localparam logic [WI_W-1:0] WI_BUCKET0 = 5'd11;

	localparam logic [CYC_W-1:0] PCT_SCALE = 32'd100;

	// count/100 as a multiply by 2^37/100 rounded up, then a shift by 37
	localparam logic [CYC_W-1:0] RECIP_100   = 32'h51EB_851F;
	localparam int               RECIP_SHIFT = 37;

	// divider step counts for the dividend widths in use
	localparam logic [DIV_STEPS_W-1:0] STEPS_32 = 7'd32;
	localparam logic [DIV_STEPS_W-1:0] STEPS_40 = 7'd40;
	localparam logic [DIV_STEPS_W-1:0] STEPS_64 = 7'd64;

	typedef struct packed {
		logic                  command;
		logic [CYC_W-1:0]      block_cycles;
		logic [CYC_W-1:0]      block_number;
		logic [DEPTH_W-1:0]    queue_depth;
		logic                  tick_coincident;
	} in_item_t;

	typedef struct packed {
		logic [WI_W-1:0]   word_index;
		logic [WORD_W-1:0] word_value;
		logic              window_empty;
		logic              last_word;
	} out_item_t;

	typedef struct packed {
		logic                   start;
		logic [WORD_W-1:0]      dividend;
		logic [CYC_W-1:0]       divisor;
		logic [DIV_STEPS_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} hist_ctl_t;

endpackage

[rtl/block_latency_histogram_monitor.sv]
// ----------------------------------------------------------------------------
// block_latency_histogram_monitor
// Latency statistics over a window of block durations with a linear histogram.
// ----------------------------------------------------------------------------
// A record beat updates the window statistics and the bucket of its duration;
// the bucket is found by 32 steps of the shared one-bit-per-cycle divider (skipped
// for a zero bucket width), then the bucket memory gets a read-modify-write.
// A report beat takes count/100 by a reciprocal multiply, runs the divider for
// the mean in 64 steps and, for a nonzero budget, for the percent of budget in 40
// steps, walks the buckets for the p99 edge, then streams 11 + BUCKETS words, the
// statistics one per cycle while the output does not stall and each bucket after
// its own memory read, and clears the window. A report on an empty window gives
// one flagged word. item_ready is high only while no beat is in work;
// configuration writes are always taken.
module block_latency_histogram_monitor
	import lhm_pkg::*;
#(
	parameter int BUCKETS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_item_t              item,
	output logic                  word_valid,
	input  logic                  word_ready,
	output out_item_t             word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(BUCKETS);
	localparam logic [AW-1:0] LAST_IDX = AW'(BUCKETS - 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REC_STAT,
		ST_REC_DIV,
		ST_REC_RD,
		ST_REC_WR,
		ST_RPT_TGT,
		ST_RPT_MEAN,
		ST_RPT_PCT,
		ST_P99_RD,
		ST_P99_ACC,
		ST_P99_MUL,
		ST_EMIT,
		ST_BKT_RD,
		ST_BKT_OUT,
		ST_EMPTY
	} state_t;

	state_t state_q;

	// configuration
	logic [CYC_W-1:0]     budget_q;
	logic [BKT_CFG_W-1:0] bucket_q;
	logic [CYC_W-1:0]     spike_cfg_q;

	// captured record
	logic [CYC_W-1:0]   cyc_q;
	logic [CYC_W-1:0]   num_q;
	logic [DEPTH_W-1:0] qd_q;
	logic               tick_q;

	// window statistics
	logic [CYC_W-1:0]   cnt_q;
	logic [CYC_W-1:0]   min_q;
	logic [WORD_W-1:0]  sum_q;
	logic [CYC_W-1:0]   spikes_q;
	logic [CYC_W-1:0]   over_q;
	logic [CYC_W-1:0]   worst_q;
	logic [CYC_W-1:0]   wnum_q;
	logic [DEPTH_W-1:0] wdepth_q;
	logic               wtick_q;

	// report scratch
	logic [CYC_W-1:0]  target_q;
	logic [CYC_W-1:0]  mean_q;
	logic [PROD_W-1:0] prod_q;
	logic [WORD_W-1:0] pct_q;
	logic [CYC_W-1:0]  cum_q;
	logic [WORD_W-1:0] p99_q;
	logic [AW-1:0]     idx_q;
	logic [WI_W-1:0]   widx_q;

	logic      word_valid_q;
	out_item_t word_q;
	div_req_t  div_req_q;
	div_rsp_t  div_rsp;

	hist_ctl_t        hist_ctl;
	logic [CYC_W-1:0] hist_rd_data;
	logic [CYC_W-1:0] cum_nx;
	logic             word_free;
	logic             idx_last;
	logic [WORD_W-1:0] stat_word;
	logic [WORD_W-1:0] tgt_prod;

	lhm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	lhm_hist #(
		.BUCKETS (BUCKETS),
		.AW      (AW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hist_ctl),
		.addr    (idx_q),
		.wr_data (hist_rd_data + 1'b1),
		.rd_data (hist_rd_data)
	);

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == ST_IDLE);
	assign word_valid = word_valid_q;
	assign word       = word_q;

	always_comb begin
		word_free    = !word_valid_q || word_ready;
		idx_last     = (idx_q == LAST_IDX);
		cum_nx       = cum_q + hist_rd_data;
		tgt_prod     = WORD_W'(cnt_q) * WORD_W'(RECIP_100);
		hist_ctl.rd  = (state_q == ST_REC_RD) || (state_q == ST_P99_RD) ||
			(state_q == ST_BKT_RD);
		hist_ctl.wr  = (state_q == ST_REC_WR);
		hist_ctl.clr = (state_q == ST_BKT_OUT) && word_free && idx_last;
	end

	always_comb begin
		case (widx_q)
			WI_COUNT:  stat_word = WORD_W'(cnt_q);
			WI_MIN:    stat_word = WORD_W'(min_q);
			WI_MEAN:   stat_word = WORD_W'(mean_q);
			WI_P99:    stat_word = p99_q;
			WI_MAX:    stat_word = WORD_W'(worst_q);
			WI_PCT:    stat_word = pct_q;
			WI_SPIKES: stat_word = WORD_W'(spikes_q);
			WI_OVER:   stat_word = WORD_W'(over_q);
			WI_NUMBER: stat_word = WORD_W'(wnum_q);
			WI_DEPTH:  stat_word = WORD_W'(wdepth_q);
			WI_TICK:   stat_word = WORD_W'(wtick_q);
			default:   stat_word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= BUDGET_RST;
			bucket_q    <= BUCKET_RST;
			spike_cfg_q <= SPIKE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BUDGET: budget_q    <= cfg_data;
				CFG_BUCKET: bucket_q    <= cfg_data[BKT_CFG_W-1:0];
				CFG_SPIKE:  spike_cfg_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cyc_q        <= '0;
			num_q        <= '0;
			qd_q         <= '0;
			tick_q       <= 1'b0;
			cnt_q        <= '0;
			min_q        <= '1;
			sum_q        <= '0;
			spikes_q     <= '0;
			over_q       <= '0;
			worst_q      <= '0;
			wnum_q       <= '0;
			wdepth_q     <= '0;
			wtick_q      <= 1'b0;
			target_q     <= '0;
			mean_q       <= '0;
			prod_q       <= '0;
			pct_q        <= '0;
			cum_q        <= '0;
			p99_q        <= '0;
			idx_q        <= '0;
			widx_q       <= '0;
			word_valid_q <= 1'b0;
			word_q       <= '0;
			div_req_q    <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (word_valid_q && word_ready) begin
				word_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						cyc_q  <= item.block_cycles;
						num_q  <= item.block_number;
						qd_q   <= item.queue_depth;
						tick_q <= item.tick_coincident;
						if (!item.command) begin
							div_req_q.start    <= (bucket_q != '0);
							div_req_q.dividend <= {item.block_cycles, 32'd0};
							div_req_q.divisor  <= CYC_W'(bucket_q);
							div_req_q.steps    <= STEPS_32;
							state_q            <= ST_REC_STAT;
						end else if (cnt_q == '0) begin
							state_q <= ST_EMPTY;
						end else begin
							// holds count/100 until the next state forms the target
							target_q <= CYC_W'(tgt_prod >> RECIP_SHIFT);
							state_q  <= ST_RPT_TGT;
						end
					end
				end
				ST_REC_STAT: begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + WORD_W'(cyc_q);
					if (cyc_q < min_q) begin
						min_q <= cyc_q;
					end
					if (cyc_q >= spike_cfg_q) begin
						spikes_q <= spikes_q + 1'b1;
					end
					if (cyc_q > budget_q) begin
						over_q <= over_q + 1'b1;
					end
					if (cyc_q > worst_q) begin
						worst_q  <= cyc_q;
						wnum_q   <= num_q;
						wdepth_q <= qd_q;
						wtick_q  <= tick_q;
					end
					// zero bucket width sends everything to the last bucket
					if (bucket_q == '0) begin
						idx_q   <= LAST_IDX;
						state_q <= ST_REC_RD;
					end else begin
						state_q <= ST_REC_DIV;
					end
				end
				ST_REC_DIV: begin
					if (div_rsp.done) begin
						idx_q   <= (div_rsp.quotient < WORD_W'(BUCKETS)) ?
							div_rsp.quotient[AW-1:0] : LAST_IDX;
						state_q <= ST_REC_RD;
					end
				end
				ST_REC_RD: begin
					state_q <= ST_REC_WR;
				end
				ST_REC_WR: begin
					state_q <= ST_IDLE;
				end
				ST_RPT_TGT: begin
					target_q           <= cnt_q - target_q;
					prod_q             <= PROD_W'(worst_q) * PROD_W'(PCT_SCALE);
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= sum_q;
					div_req_q.divisor  <= cnt_q;
					div_req_q.steps    <= STEPS_64;
					state_q            <= ST_RPT_MEAN;
				end
				ST_RPT_MEAN: begin
					if (div_rsp.done) begin
						mean_q <= div_rsp.quotient[CYC_W-1:0];
						if (budget_q == '0) begin
							pct_q   <= '1;
							idx_q   <= '0;
							cum_q   <= '0;
							state_q <= ST_P99_RD;
						end else begin
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= {prod_q, 24'd0};
							div_req_q.divisor  <= budget_q;
							div_req_q.steps    <= STEPS_40;
							state_q            <= ST_RPT_PCT;
						end
					end
				end
				ST_RPT_PCT: begin
					if (div_rsp.done) begin
						pct_q   <= div_rsp.quotient;
						idx_q   <= '0;
						cum_q   <= '0;
						state_q <= ST_P99_RD;
					end
				end
				ST_P99_RD: begin
					state_q <= ST_P99_ACC;
				end
				ST_P99_ACC: begin
					cum_q <= cum_nx;
					// idx_q stays on the p99 bucket when the walk stops
					if (cum_nx >= target_q || idx_last) begin
						state_q <= ST_P99_MUL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_P99_RD;
					end
				end
				ST_P99_MUL: begin
					p99_q   <= WORD_W'(({1'b0, idx_q} + 1'b1) * (AW + 1 + BKT_CFG_W)'(bucket_q));
					widx_q  <= WI_COUNT;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (word_free) begin
						word_valid_q        <= 1'b1;
						word_q.word_index   <= widx_q;
						word_q.word_value   <= stat_word;
						word_q.window_empty <= 1'b0;
						word_q.last_word    <= 1'b0;
						if (widx_q == WI_TICK) begin
							idx_q   <= '0;
							state_q <= ST_BKT_RD;
						end else begin
							widx_q <= widx_q + 1'b1;
						end
					end
				end
				ST_BKT_RD: begin
					state_q <= ST_BKT_OUT;
				end
				ST_BKT_OUT: begin
					if (word_free) begin
						word_valid_q        <= 1'b1;
						word_q.word_index   <= WI_BUCKET0 + WI_W'(idx_q);
						word_q.word_value   <= WORD_W'(hist_rd_data);
						word_q.window_empty <= 1'b0;
						word_q.last_word    <= idx_last;
						if (idx_last) begin
							cnt_q    <= '0;
							min_q    <= '1;
							sum_q    <= '0;
							spikes_q <= '0;
							over_q   <= '0;
							worst_q  <= '0;
							wnum_q   <= '0;
							wdepth_q <= '0;
							wtick_q  <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_BKT_RD;
						end
					end
				end
				ST_EMPTY: begin
					if (word_free) begin
						word_valid_q        <= 1'b1;
						word_q.word_index   <= WI_COUNT;
						word_q.word_value   <= '0;
						word_q.window_empty <= 1'b1;
						word_q.last_word    <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the shared divider is never restarted mid-run
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req_q.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !div_rsp.busy && !div_req_q.start)
		else $error("ready while a division is in flight");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word.window_empty |-> word.last_word && word.word_index == WI_COUNT)
		else $error("empty report word malformed");

	a_clear_window: assert property (@(posedge clk) disable iff (!arst_n)
		hist_ctl.clr |=> cnt_q == '0 && sum_q == '0 && worst_q == '0 && state_q == ST_IDLE)
		else $error("window not cleared after last bucket");

endmodule

[rtl/lhm_div.sv]
// ----------------------------------------------------------------------------
// lhm_div
// Shared restoring divider, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module lhm_div
	import lhm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_STEPS_W-1:0] cnt_q;
	logic [CYC_W-1:0]       rem_q;
	logic [WORD_W-1:0]      dvd_q;
	logic [CYC_W-1:0]       dvs_q;

	logic [CYC_W:0] rem_sh;
	logic           ge;
	logic [CYC_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, dvd_q[WORD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? CYC_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CYC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEPS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend is left-aligned by the caller; quotient bits shift in from the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

[rtl/lhm_hist.sv]
// ----------------------------------------------------------------------------
// lhm_hist
// Histogram bucket memory, one port, registered read, per-entry valid bits.
// ----------------------------------------------------------------------------
module lhm_hist
	import lhm_pkg::*;
#(
	parameter int BUCKETS = 16,
	parameter int AW      = $clog2(BUCKETS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hist_ctl_t        ctl,
	input  logic [AW-1:0]    addr,
	input  logic [CYC_W-1:0] wr_data,
	output logic [CYC_W-1:0] rd_data
);

	logic [CYC_W-1:0] mem [BUCKETS];
	logic [CYC_W-1:0] rd_data_q;
	logic [BUCKETS-1:0] valid_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	// a bucket never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block latency histogram monitor: queued record
// and report beats feed the block under random idling on both sides, and a
// behavioral copy of the window statistics predicts every report word.
// ----------------------------------------------------------------------------
module tb;
	import lhm_pkg::*;

	localparam int NUM_BUCKETS = 16;
	localparam int HOLD_CYCLES = 1000;
	localparam int SETTLE_CYCLES = 64;
	localparam int TAIL_CYCLES = 400;
	localparam int LIMIT_CYCLES = 1000000;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_REPORT = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic word_valid;
	logic word_ready = 1'b0;
	out_item_t word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus bookkeeping
	in_item_t pending_items[$];
	out_item_t expected_words[$];
	int items_sent = 0;
	int items_done = 0;
	int idle_pct = 38;
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;
	int errors = 0;
	int cycle_count = 0;

	// configuration copy
	logic [CYC_W-1:0] budget_reg;
	logic [BKT_CFG_W-1:0] bucket_width;
	logic [CYC_W-1:0] spike_level;

	// window statistics copy
	logic [31:0] win_count;
	logic [31:0] win_min;
	logic [63:0] win_sum;
	logic [31:0] win_spikes;
	logic [31:0] win_over;
	logic [31:0] hist [NUM_BUCKETS];
	logic [31:0] worst_cyc;
	logic [31:0] worst_num;
	logic [15:0] worst_qd;
	logic worst_tk;

	block_latency_histogram_monitor #(
		.BUCKETS(NUM_BUCKETS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word(word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task clear_window();
		win_count = '0;
		win_min = '1;
		win_sum = '0;
		win_spikes = '0;
		win_over = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) hist[i] = '0;
		worst_cyc = '0;
		worst_num = '0;
		worst_qd = '0;
		worst_tk = 1'b0;
	endtask

	task record_block(input in_item_t it);
		int unsigned slot;
		logic [31:0] quot;
		slot = NUM_BUCKETS - 1;
		win_count = win_count + 1;
		win_sum = win_sum + 64'(it.block_cycles);
		if (it.block_cycles < win_min) win_min = it.block_cycles;
		if (bucket_width != 0) begin
			quot = it.block_cycles / 32'(bucket_width);
			if (quot < NUM_BUCKETS) slot = quot;
		end
		hist[slot] = hist[slot] + 1;
		if (it.block_cycles >= spike_level) win_spikes = win_spikes + 1;
		if (it.block_cycles > budget_reg) win_over = win_over + 1;
		if (it.block_cycles > worst_cyc) begin
			worst_cyc = it.block_cycles;
			worst_num = it.block_number;
			worst_qd = it.queue_depth;
			worst_tk = it.tick_coincident;
		end
	endtask

	task push_word(input logic [WI_W-1:0] idx, input logic [63:0] val, input logic empty,
			input logic last);
		out_item_t w;
		w.word_index = idx;
		w.word_value = val;
		w.window_empty = empty;
		w.last_word = last;
		expected_words.push_back(w);
	endtask

	task emit_report();
		logic [31:0] target;
		logic [31:0] running;
		logic [31:0] mean_q;
		logic [63:0] pct;
		int unsigned edge_bucket;
		bit found;
		if (win_count == 0) begin
			push_word(WI_COUNT, 64'd0, 1'b1, 1'b1);
			return;
		end
		mean_q = 32'(win_sum / 64'(win_count));
		target = win_count - win_count / 32'd100;
		running = '0;
		found = 1'b0;
		edge_bucket = NUM_BUCKETS - 1;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			running = running + hist[i];
			if (!found && running >= target) begin
				edge_bucket = i;
				found = 1'b1;
			end
		end
		if (budget_reg != 0)
			pct = (64'(worst_cyc) * 64'd100) / 64'(budget_reg);
		else
			pct = '1;
		push_word(WI_COUNT, 64'(win_count), 1'b0, 1'b0);
		push_word(WI_MIN, 64'(win_min), 1'b0, 1'b0);
		push_word(WI_MEAN, 64'(mean_q), 1'b0, 1'b0);
		push_word(WI_P99, 64'(edge_bucket + 1) * 64'(bucket_width), 1'b0, 1'b0);
		push_word(WI_MAX, 64'(worst_cyc), 1'b0, 1'b0);
		push_word(WI_PCT, pct, 1'b0, 1'b0);
		push_word(WI_SPIKES, 64'(win_spikes), 1'b0, 1'b0);
		push_word(WI_OVER, 64'(win_over), 1'b0, 1'b0);
		push_word(WI_NUMBER, 64'(worst_num), 1'b0, 1'b0);
		push_word(WI_DEPTH, 64'(worst_qd), 1'b0, 1'b0);
		push_word(WI_TICK, 64'(worst_tk), 1'b0, 1'b0);
		for (int i = 0; i < NUM_BUCKETS; i++)
			push_word(WI_BUCKET0 + WI_W'(i), 64'(hist[i]), 1'b0, i == NUM_BUCKETS - 1);
		clear_window();
	endtask

	// driver: one beat per handshake, payload held until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				if (item.command == CMD_RECORD)
					record_block(item);
				else
					emit_report();
				items_done++;
			end
			if (!item_valid || item_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task check_word(input out_item_t got);
		out_item_t want;
		if (expected_words.size() == 0) begin
			$error("word beat with nothing expected: word_index %0d, word_value 0x%0h",
				got.word_index, got.word_value);
			errors++;
			return;
		end
		want = expected_words.pop_front();
		if (got.word_index !== want.word_index) begin
			$error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
			errors++;
		end
		if (got.word_value !== want.word_value) begin
			$error("word_value (word %0d): expected 0x%0h, actual 0x%0h",
				want.word_index, want.word_value, got.word_value);
			errors++;
		end
		if (got.window_empty !== want.window_empty) begin
			$error("window_empty (word %0d): expected %0d, actual %0d",
				want.word_index, want.window_empty, got.window_empty);
			errors++;
		end
		if (got.last_word !== want.last_word) begin
			$error("last_word (word %0d): expected %0d, actual %0d",
				want.word_index, want.last_word, got.last_word);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && word_valid && word_ready) check_word(word);
		word_ready <= arst_n && hold_left == 0 && $urandom_range(99, 0) >= idle_pct;
	end

	// long receiver hold-off, one per request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_req) begin
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("block_latency_histogram_monitor regression: fail");
			$finish;
		end
	end

	task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_BUDGET: budget_reg = data;
			CFG_BUCKET: bucket_width = data[BKT_CFG_W-1:0];
			CFG_SPIKE: spike_level = data;
			default: ;
		endcase
	endtask

	// wait for every beat to be taken and every word to arrive, then let work finish
	task drain();
		while (items_done != items_sent || expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task queue_item(input in_item_t it);
		pending_items.push_back(it);
		items_sent++;
	endtask

	function automatic in_item_t make_item(input logic cmd, input logic [31:0] cyc);
		in_item_t it;
		it.command = cmd;
		it.block_cycles = cyc;
		it.block_number = $urandom();
		it.queue_depth = 16'($urandom());
		it.tick_coincident = 1'($urandom_range(1, 0));
		return it;
	endfunction

	function automatic logic [31:0] random_cycles();
		logic [63:0] span;
		if (bucket_width == 0)
			span = 64'd1000000;
		else
			span = 64'(bucket_width) * (NUM_BUCKETS + 2);
		if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
		case ($urandom_range(9, 0))
			0: begin
				case ($urandom_range(5, 0))
					0: return '0;
					1: return '1;
					2: return budget_reg;
					3: return budget_reg + 1;
					4: return spike_level;
					default: return spike_level - 1;
				endcase
			end
			1: return $urandom();
			default: return $urandom_range(32'(span), 0);
		endcase
	endfunction

	task queue_records(input int n);
		for (int i = 0; i < n; i++) queue_item(make_item(CMD_RECORD, random_cycles()));
	endtask

	task random_phase(input int n);
		for (int i = 0; i < n - 1; i++) begin
			if ($urandom_range(99, 0) < 8)
				queue_item(make_item(CMD_REPORT, $urandom()));
			else
				queue_item(make_item(CMD_RECORD, random_cycles()));
		end
		queue_item(make_item(CMD_REPORT, $urandom()));
	endtask

	task random_config();
		logic [31:0] w;
		logic [31:0] b;
		w = $urandom_range(150000, 1);
		b = w * $urandom_range(20, 8);
		cfg_write(CFG_BUCKET, w);
		cfg_write(CFG_BUDGET, b);
		cfg_write(CFG_SPIKE, b - b / $urandom_range(10, 2));
	endtask

	initial begin
		in_item_t it;
		budget_reg = BUDGET_RST;
		bucket_width = BUCKET_RST;
		spike_level = SPIKE_RST;
		clear_window();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: empty report, field extremes, bucket and threshold edges
		cfg_write(CFG_BUDGET, BUDGET_RST);
		cfg_write(CFG_BUCKET, 32'(BUCKET_RST));
		cfg_write(CFG_SPIKE, SPIKE_RST);
		queue_item(make_item(CMD_REPORT, '1));
		it = '0;
		queue_item(it);
		it = '1;
		it.command = CMD_RECORD;
		queue_item(it);
		queue_item(make_item(CMD_RECORD, '1));
		queue_item(make_item(CMD_RECORD, 32'd79999));
		queue_item(make_item(CMD_RECORD, 32'd80000));
		queue_item(make_item(CMD_RECORD, 32'd1279999));
		queue_item(make_item(CMD_RECORD, 32'd1280000));
		queue_item(make_item(CMD_RECORD, 32'd1280001));
		queue_item(make_item(CMD_RECORD, 32'd1024000));
		queue_item(make_item(CMD_RECORD, 32'd1023999));
		queue_item(make_item(CMD_REPORT, 32'd0));
		queue_item(make_item(CMD_REPORT, 32'd0));
		drain();

		// zero budget, zero bucket width (upper bits masked off), zero spike level
		cfg_write(CFG_BUDGET, 32'd0);
		cfg_write(CFG_BUCKET, 32'hF000_0000);
		cfg_write(CFG_SPIKE, 32'd0);
		cfg_write(CFG_UNUSED, '1);
		queue_item(make_item(CMD_RECORD, 32'd0));
		queue_item(make_item(CMD_RECORD, 32'd5));
		queue_item(make_item(CMD_RECORD, 32'd12345));
		queue_item(make_item(CMD_REPORT, 32'd0));
		drain();

		// largest settings
		cfg_write(CFG_BUDGET, '1);
		cfg_write(CFG_BUCKET, 32'h0FFF_FFFF);
		cfg_write(CFG_SPIKE, '1);
		queue_item(make_item(CMD_RECORD, '1));
		queue_item(make_item(CMD_RECORD, 32'hFFFF_FFFE));
		queue_item(make_item(CMD_RECORD, 32'h2FFF_FFFD));
		queue_item(make_item(CMD_REPORT, 32'd0));
		drain();

		cfg_write(CFG_BUDGET, BUDGET_RST);
		cfg_write(CFG_BUCKET, 32'(BUCKET_RST));
		cfg_write(CFG_SPIKE, SPIKE_RST);
		random_phase(40);
		drain();

		// receiver holds off while reports pile up behind it
		random_config();
		hold_req++;
		for (int r = 0; r < 3; r++) begin
			queue_records(6);
			queue_item(make_item(CMD_REPORT, $urandom()));
		end
		drain();

		// one long window, deep enough for the p99 trim, with no idling
		random_config();
		idle_pct = 0;
		queue_records(110);
		queue_item(make_item(CMD_REPORT, $urandom()));
		drain();
		idle_pct = 38;

		for (int p = 0; p < 4; p++) begin
			random_config();
			random_phase(22);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("block_latency_histogram_monitor regression: pass");
		else
			$display("block_latency_histogram_monitor regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/lhm_pkg.sv
rtl/lhm_div.sv
rtl/lhm_hist.sv
rtl/block_latency_histogram_monitor.sv
dv/tb.sv
